>>> sv/npt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npt_pkg
// Shared types and constants of the node presence table.
// ----------------------------------------------------------------------------
package npt_pkg;

    localparam int MAC_W   = 48;
    localparam int TIME_W  = 48;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 6;
    localparam int TMO_W   = 24;
    localparam int KIND_W  = 2;

    localparam logic [TMO_W-1:0] TMO_RESET = 24'd90000;

    localparam logic OP_HEARTBEAT = 1'b0;
    localparam logic OP_READ      = 1'b1;

    localparam logic [KIND_W-1:0] KIND_HB    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] seen;
        logic [BYTE_W-1:0] summary_state;
        logic [BYTE_W-1:0] machine_state;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HB_SCAN,
        S_RD_SCAN
    } t_state;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_HB_HIT,
        ACT_HB_NEW,
        ACT_HB_FULL,
        ACT_ENTRY,
        ACT_EMPTY
    } t_act;

    typedef struct packed {
        logic rd_en;
        t_act act;
        logic last;
    } t_ctrl;

endpackage : npt_pkg
`default_nettype wire

>>> sv/npt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npt_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module npt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : npt_ram
`default_nettype wire

>>> sv/npt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npt_ctrl
// Sequencer: walks the table with a pipelined read pointer, tracks the
// entry count and decides the result action of each cycle.
// ----------------------------------------------------------------------------
module npt_ctrl #(
    parameter int NODES = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_accept,
    input  wire logic                                   i_op,
    input  wire logic                                   i_hit,
    output      logic                                   o_busy,
    output      npt_pkg::t_ctrl                         o_ctrl,
    output      logic [(NODES > 1 ? $clog2(NODES) : 1)-1:0] o_rd_addr,
    output      logic [$clog2(NODES + 1)-1:0]           o_res_idx,
    output      logic [$clog2(NODES + 1)-1:0]           o_count_next
);
    import npt_pkg::*;

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);
    localparam logic [CW-1:0] NODES_C = CW'(NODES);

    t_state        r_state, n_state;
    logic [CW-1:0] r_ptr, n_ptr;
    logic          r_pend, n_pend;
    logic [CW-1:0] r_pidx, n_pidx;
    logic [CW-1:0] r_count, n_count;

    logic issue;
    logic miss;
    logic is_last;

    assign issue   = (r_ptr < r_count);
    assign miss    = !issue && !r_pend;
    assign is_last = (CW'(r_pidx + CW'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            r_pend  <= 1'b0;
            r_pidx  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_pend  <= n_pend;
            r_pidx  <= n_pidx;
            r_count <= n_count;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_pend  = 1'b0;
        n_pidx  = r_ptr;
        n_count = r_count;
        case (r_state)
            S_IDLE: begin
                n_ptr = '0;
                if (i_accept) begin
                    n_state = (i_op == OP_READ) ? S_RD_SCAN : S_HB_SCAN;
                end
            end
            S_HB_SCAN: begin
                n_pend = issue;
                if (issue) begin
                    n_ptr = CW'(r_ptr + CW'(1));
                end
                if (r_pend && i_hit) begin
                    n_state = S_IDLE;
                end else if (miss) begin
                    n_state = S_IDLE;
                    if (r_count != NODES_C) begin
                        n_count = CW'(r_count + CW'(1));
                    end
                end
            end
            S_RD_SCAN: begin
                n_pend = issue;
                if (issue) begin
                    n_ptr = CW'(r_ptr + CW'(1));
                end
                if (r_count == '0) begin
                    n_state = S_IDLE;
                end else if (r_pend && is_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl.rd_en = 1'b0;
        o_ctrl.act   = ACT_NONE;
        o_ctrl.last  = 1'b0;
        o_res_idx    = r_pidx;
        case (r_state)
            S_HB_SCAN: begin
                o_ctrl.rd_en = issue;
                o_ctrl.last  = 1'b1;
                if (r_pend && i_hit) begin
                    o_ctrl.act = ACT_HB_HIT;
                end else if (miss) begin
                    o_res_idx  = r_count;
                    o_ctrl.act = (r_count == NODES_C) ? ACT_HB_FULL : ACT_HB_NEW;
                end
            end
            S_RD_SCAN: begin
                o_ctrl.rd_en = issue;
                if (r_count == '0) begin
                    o_ctrl.act  = ACT_EMPTY;
                    o_ctrl.last = 1'b1;
                end else if (r_pend) begin
                    o_ctrl.act  = ACT_ENTRY;
                    o_ctrl.last = is_last;
                end
            end
            default: begin
                o_ctrl.act = ACT_NONE;
            end
        endcase
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_rd_addr    = r_ptr[IW-1:0];
    assign o_count_next = n_count;

endmodule : npt_ctrl
`default_nettype wire

>>> sv/node_presence_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// node_presence_table_core
// Presence table of network nodes keyed by MAC, with aging to offline.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken at a clock edge with start high and
//   busy low. i_operation selects heartbeat or age-and-read.
//   Result channel: each result beat is on the o_* ports for one cycle with
//   o_valid high; the receiver cannot stall, so no beat is ever held.
//   Config: i_cfg_we writes i_cfg_wdata into the offline timeout; write only
//   while busy is low.
//   Heartbeat: linear search of the entry RAM, one entry per cycle through
//   the one read port; the search ends on a hit or, past the last entry,
//   with an append or a full table result. Busy drops with that beat.
//   Read: one pass over the RAM ages each entry and streams it, one beat
//   per cycle after the registered RAM read; an empty table gives a single
//   empty beat. Busy drops with the last beat. The next item is taken at
//   the edge ending that beat.
//   Reset: synchronous, clears the entry count, online flags and the
//   timeout to 90000 ms. RAM contents need no clearing pass.
// ----------------------------------------------------------------------------
module node_presence_table_core #(
    parameter int NODES = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output      logic                                  busy,
    input  wire logic                                  i_operation,
    input  wire logic [npt_pkg::MAC_W-1:0]             i_mac,
    input  wire logic [npt_pkg::BYTE_W-1:0]            i_summary_state,
    input  wire logic [npt_pkg::BYTE_W-1:0]            i_machine_state,
    input  wire logic [npt_pkg::TIME_W-1:0]            i_now_ms,
    input  wire logic                                  i_cfg_we,
    input  wire logic [npt_pkg::TMO_W-1:0]             i_cfg_wdata,
    output      logic                                  o_valid,
    output      logic [npt_pkg::KIND_W-1:0]            o_kind,
    output      logic [npt_pkg::IDX_W-1:0]             o_node_index,
    output      logic                                  o_table_full,
    output      logic [npt_pkg::MAC_W-1:0]             o_node_mac,
    output      logic                                  o_online,
    output      logic [npt_pkg::BYTE_W-1:0]            o_node_summary_state,
    output      logic [npt_pkg::BYTE_W-1:0]            o_node_machine_state,
    output      logic [npt_pkg::CNT_W-1:0]             o_node_count,
    output      logic                                  o_last
);
    import npt_pkg::*;

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);

    logic                r_valid;
    logic [TMO_W-1:0]    r_timeout;
    logic [NODES-1:0]    r_online, n_online;

    logic [MAC_W-1:0]    r_mac;
    logic [BYTE_W-1:0]   r_ss;
    logic [BYTE_W-1:0]   r_ms;
    logic [TIME_W-1:0]   r_now;

    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_full, n_full;
    logic [MAC_W-1:0]    r_omac, n_omac;
    logic                r_onl, n_onl;
    logic [BYTE_W-1:0]   r_oss, n_oss;
    logic [BYTE_W-1:0]   r_oms, n_oms;
    logic [CNT_W-1:0]    r_ocnt, n_ocnt;
    logic                r_last, n_last;

    logic                accept;
    t_ctrl               ctrl;
    logic [IW-1:0]       rd_addr;
    logic [CW-1:0]       res_idx;
    logic [CW-1:0]       count_next;
    t_entry              rdata;
    t_entry              wdata;
    logic                we;
    logic                hit;
    logic                aged;
    logic [TIME_W-1:0]   age;

    assign accept = start && !busy;

    npt_ctrl #(
        .NODES (NODES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (i_operation),
        .i_hit        (hit),
        .o_busy       (busy),
        .o_ctrl       (ctrl),
        .o_rd_addr    (rd_addr),
        .o_res_idx    (res_idx),
        .o_count_next (count_next)
    );

    npt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (res_idx[IW-1:0]),
        .i_wdata (wdata),
        .i_re    (ctrl.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign hit  = (rdata.mac == r_mac);
    assign age  = r_now - rdata.seen;
    assign aged = (age > TIME_W'(r_timeout));

    assign we                  = (ctrl.act == ACT_HB_HIT) || (ctrl.act == ACT_HB_NEW);
    assign wdata.mac           = r_mac;
    assign wdata.seen          = r_now;
    assign wdata.summary_state = r_ss;
    assign wdata.machine_state = r_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_timeout <= TMO_RESET;
            r_online  <= '0;
        end else begin
            r_valid  <= (ctrl.act != ACT_NONE);
            r_online <= n_online;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mac <= i_mac;
            r_ss  <= i_summary_state;
            r_ms  <= i_machine_state;
            r_now <= i_now_ms;
        end
        r_kind <= n_kind;
        r_idx  <= n_idx;
        r_full <= n_full;
        r_omac <= n_omac;
        r_onl  <= n_onl;
        r_oss  <= n_oss;
        r_oms  <= n_oms;
        r_ocnt <= n_ocnt;
        r_last <= n_last;
    end

    // result beat and online flag update
    always_comb begin
        n_online = r_online;
        n_kind   = KIND_HB;
        n_idx    = '0;
        n_full   = 1'b0;
        n_omac   = '0;
        n_onl    = 1'b0;
        n_oss    = '0;
        n_oms    = '0;
        n_ocnt   = CNT_W'(count_next);
        n_last   = ctrl.last;
        case (ctrl.act)
            ACT_HB_HIT, ACT_HB_NEW: begin
                n_online[res_idx[IW-1:0]] = 1'b1;
                n_idx  = IDX_W'(res_idx);
                n_omac = r_mac;
                n_onl  = 1'b1;
                n_oss  = r_ss;
                n_oms  = r_ms;
            end
            ACT_HB_FULL: begin
                n_full = 1'b1;
                n_omac = r_mac;
            end
            ACT_ENTRY: begin
                if (aged) begin
                    n_online[res_idx[IW-1:0]] = 1'b0;
                end
                n_kind = KIND_ENTRY;
                n_idx  = IDX_W'(res_idx);
                n_omac = rdata.mac;
                n_onl  = r_online[res_idx[IW-1:0]] && !aged;
                n_oss  = rdata.summary_state;
                n_oms  = rdata.machine_state;
            end
            ACT_EMPTY: begin
                n_kind = KIND_EMPTY;
                n_ocnt = '0;
            end
            default: begin
                n_kind = KIND_HB;
            end
        endcase
    end

    assign o_valid              = r_valid;
    assign o_kind               = r_kind;
    assign o_node_index         = r_idx;
    assign o_table_full         = r_full;
    assign o_node_mac           = r_omac;
    assign o_online             = r_onl;
    assign o_node_summary_state = r_oss;
    assign o_node_machine_state = r_oms;
    assign o_node_count         = r_ocnt;
    assign o_last               = r_last;

endmodule : node_presence_table_core
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for node_presence_table_core.
// A directed table covers the empty read, extreme field values, the aging
// boundary, timestamps in the future and a full table. A random phase per
// offline timeout (0, max, reset value, two random) then mixes heartbeats from
// known and unknown nodes with reads. Each result beat is checked field by
// field against an in-bench presence table model, in order.
// ----------------------------------------------------------------------------
module tb;
    import npt_pkg::*;

    localparam int NODES = 16;
    localparam int ITEMS_PER_PHASE = 40;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  idx;
        logic              full;
        logic [MAC_W-1:0]  mac;
        logic              online;
        logic [BYTE_W-1:0] ss;
        logic [BYTE_W-1:0] ms;
        logic [CNT_W-1:0]  cnt;
        logic              last;
    } t_beat;

    typedef struct packed {
        logic              op;
        logic [MAC_W-1:0]  mac;
        logic [BYTE_W-1:0] ss;
        logic [BYTE_W-1:0] ms;
        logic [TIME_W-1:0] now;
        logic              typed;
        t_beat             fixed;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_operation;
    logic [MAC_W-1:0]    i_mac;
    logic [BYTE_W-1:0]   i_summary_state;
    logic [BYTE_W-1:0]   i_machine_state;
    logic [TIME_W-1:0]   i_now_ms;
    logic                i_cfg_we;
    logic [TMO_W-1:0]    i_cfg_wdata;
    logic                o_valid;
    logic [KIND_W-1:0]   o_kind;
    logic [IDX_W-1:0]    o_node_index;
    logic                o_table_full;
    logic [MAC_W-1:0]    o_node_mac;
    logic                o_online;
    logic [BYTE_W-1:0]   o_node_summary_state;
    logic [BYTE_W-1:0]   o_node_machine_state;
    logic [CNT_W-1:0]    o_node_count;
    logic                o_last;

    // presence table model
    logic [MAC_W-1:0]    tbl_mac [NODES];
    logic [TIME_W-1:0]   tbl_seen[NODES];
    logic                tbl_onl [NODES];
    logic [BYTE_W-1:0]   tbl_ss  [NODES];
    logic [BYTE_W-1:0]   tbl_ms  [NODES];
    int                  node_cnt;
    logic [TMO_W-1:0]    node_tmo;

    t_beat               expected_beats[$];
    t_stim_row           dir_rows[$];
    t_beat               got_beat;
    t_beat               want_beat;
    bit                  idle_ok;
    int                  err_count;
    int                  n_hb;
    int                  n_read;
    int                  n_full;
    int                  n_beats;

    node_presence_table_core #(
        .NODES(NODES)
    ) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_operation         (i_operation),
        .i_mac               (i_mac),
        .i_summary_state     (i_summary_state),
        .i_machine_state     (i_machine_state),
        .i_now_ms            (i_now_ms),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .o_valid             (o_valid),
        .o_kind              (o_kind),
        .o_node_index        (o_node_index),
        .o_table_full        (o_table_full),
        .o_node_mac          (o_node_mac),
        .o_online            (o_online),
        .o_node_summary_state(o_node_summary_state),
        .o_node_machine_state(o_node_machine_state),
        .o_node_count        (o_node_count),
        .o_last              (o_last)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_beat make_beat(input logic [KIND_W-1:0] kind, input int idx,
                                        input logic full, input logic [MAC_W-1:0] mac,
                                        input logic onl, input logic [BYTE_W-1:0] ss,
                                        input logic [BYTE_W-1:0] ms, input int cnt,
                                        input logic last);
        t_beat b;
        b.kind   = kind;
        b.idx    = IDX_W'(idx);
        b.full   = full;
        b.mac    = mac;
        b.online = onl;
        b.ss     = ss;
        b.ms     = ms;
        b.cnt    = CNT_W'(cnt);
        b.last   = last;
        return b;
    endfunction

    task automatic presence_step(input logic op, input logic [MAC_W-1:0] mac,
                                 input logic [BYTE_W-1:0] ss, input logic [BYTE_W-1:0] ms,
                                 input logic [TIME_W-1:0] now, input bit enqueue);
        int hit;
        logic [TIME_W-1:0] age;
        t_beat b;
        if (op == OP_HEARTBEAT) begin
            hit = -1;
            for (int i = 0; i < node_cnt; i++) begin
                if (hit < 0 && tbl_mac[i] == mac) begin
                    hit = i;
                end
            end
            if (hit < 0 && node_cnt >= NODES) begin
                b = make_beat(KIND_HB, 0, 1'b1, mac, 1'b0, '0, '0, node_cnt, 1'b1);
                n_full++;
            end else begin
                if (hit < 0) begin
                    hit = node_cnt;
                    tbl_mac[hit] = mac;
                    node_cnt++;
                end
                tbl_ss[hit]   = ss;
                tbl_ms[hit]   = ms;
                tbl_seen[hit] = now;
                tbl_onl[hit]  = 1'b1;
                b = make_beat(KIND_HB, hit, 1'b0, tbl_mac[hit], 1'b1, ss, ms, node_cnt, 1'b1);
            end
            if (enqueue) begin
                expected_beats.push_back(b);
            end
        end else begin
            for (int i = 0; i < node_cnt; i++) begin
                age = now - tbl_seen[i];
                if (age > TIME_W'(node_tmo)) begin
                    tbl_onl[i] = 1'b0;
                end
            end
            if (!enqueue) begin
                // typed row supplies the beat
            end else if (node_cnt == 0) begin
                expected_beats.push_back(make_beat(KIND_EMPTY, 0, 1'b0, '0, 1'b0, '0, '0,
                                                   0, 1'b1));
            end else begin
                for (int i = 0; i < node_cnt; i++) begin
                    expected_beats.push_back(make_beat(KIND_ENTRY, i, 1'b0, tbl_mac[i],
                                                       tbl_onl[i], tbl_ss[i], tbl_ms[i],
                                                       node_cnt, i == node_cnt - 1));
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        if (err_count <= 40) begin
            $display("MISMATCH beat %0d %s: got %h expected %h", n_beats, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            got_beat.kind   = o_kind;
            got_beat.idx    = o_node_index;
            got_beat.full   = o_table_full;
            got_beat.mac    = o_node_mac;
            got_beat.online = o_online;
            got_beat.ss     = o_node_summary_state;
            got_beat.ms     = o_node_machine_state;
            got_beat.cnt    = o_node_count;
            got_beat.last   = o_last;
            if (expected_beats.size() == 0) begin
                report_mismatch("beat with nothing expected, kind", 64'(o_kind), '0);
            end else begin
                want_beat = expected_beats.pop_front();
                if (got_beat.kind !== want_beat.kind)
                    report_mismatch("kind", 64'(got_beat.kind), 64'(want_beat.kind));
                if (got_beat.idx !== want_beat.idx)
                    report_mismatch("node_index", 64'(got_beat.idx), 64'(want_beat.idx));
                if (got_beat.full !== want_beat.full)
                    report_mismatch("table_full", 64'(got_beat.full), 64'(want_beat.full));
                if (got_beat.mac !== want_beat.mac)
                    report_mismatch("node_mac", 64'(got_beat.mac), 64'(want_beat.mac));
                if (got_beat.online !== want_beat.online)
                    report_mismatch("online", 64'(got_beat.online), 64'(want_beat.online));
                if (got_beat.ss !== want_beat.ss)
                    report_mismatch("summary_state", 64'(got_beat.ss), 64'(want_beat.ss));
                if (got_beat.ms !== want_beat.ms)
                    report_mismatch("machine_state", 64'(got_beat.ms), 64'(want_beat.ms));
                if (got_beat.cnt !== want_beat.cnt)
                    report_mismatch("node_count", 64'(got_beat.cnt), 64'(want_beat.cnt));
                if (got_beat.last !== want_beat.last)
                    report_mismatch("last", 64'(got_beat.last), 64'(want_beat.last));
            end
            n_beats++;
        end
    end

    task automatic send_item(input logic op, input logic [MAC_W-1:0] mac,
                             input logic [BYTE_W-1:0] ss, input logic [BYTE_W-1:0] ms,
                             input logic [TIME_W-1:0] now, input logic typed,
                             input t_beat fixed);
        if (idle_ok) begin
            while ($urandom_range(0, 99) < 32) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start           <= 1'b1;
        i_operation     <= op;
        i_mac           <= mac;
        i_summary_state <= ss;
        i_machine_state <= ms;
        i_now_ms        <= now;
        do @(posedge i_clk); while (busy !== 1'b0);
        presence_step(op, mac, ss, ms, now, !typed);
        if (typed) begin
            expected_beats.push_back(fixed);
        end
        if (op == OP_HEARTBEAT) n_hb++;
        else n_read++;
    endtask

    // called in the step of the last accepted item
    task automatic drain();
        start <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (NODES + 4) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [TMO_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        node_tmo     = value;
    endtask

    task automatic add_row(input logic op, input logic [MAC_W-1:0] mac,
                           input logic [BYTE_W-1:0] ss, input logic [BYTE_W-1:0] ms,
                           input logic [TIME_W-1:0] now, input logic typed,
                           input t_beat fixed);
        t_stim_row row;
        row.op    = op;
        row.mac   = mac;
        row.ss    = ss;
        row.ms    = ms;
        row.now   = now;
        row.typed = typed;
        row.fixed = fixed;
        dir_rows.push_back(row);
    endtask

    task automatic load_directed();
        t_beat none;
        logic [MAC_W-1:0] ones;
        none = '0;
        ones = '1;
        add_row(OP_READ, ones, 8'hFF, 8'hFF, '0, 1'b1,
                make_beat(KIND_EMPTY, 0, 1'b0, '0, 1'b0, '0, '0, 0, 1'b1));
        add_row(OP_HEARTBEAT, '0, 8'h00, 8'h00, '0, 1'b1,
                make_beat(KIND_HB, 0, 1'b0, '0, 1'b1, 8'h00, 8'h00, 1, 1'b1));
        add_row(OP_HEARTBEAT, ones, 8'hFF, 8'hFF, ones, 1'b1,
                make_beat(KIND_HB, 1, 1'b0, ones, 1'b1, 8'hFF, 8'hFF, 2, 1'b1));
        add_row(OP_HEARTBEAT, '0, 8'h5A, 8'hA5, 48'd100, 1'b0, none);
        // entry 1 was stamped at max time: age wraps to a small value
        add_row(OP_READ, '0, '0, '0, 48'd100, 1'b0, none);
        // age exactly at the timeout stays online, one past goes offline
        add_row(OP_READ, '0, '0, '0, 48'd90100, 1'b0, none);
        // stamp in the future looks very old
        add_row(OP_READ, '0, '0, '0, 48'd50, 1'b0, none);
        for (int i = 2; i < NODES; i++) begin
            add_row(OP_HEARTBEAT, 48'h5A5A_0000_0000 + MAC_W'(i) * 48'h0001_0203_0405,
                    BYTE_W'(i), 8'hFF - BYTE_W'(i), 48'd1000 + TIME_W'(i), 1'b0, none);
        end
        add_row(OP_HEARTBEAT, 48'hC0FF_EE00_1234, 8'h11, 8'h22, 48'd2000, 1'b1,
                make_beat(KIND_HB, 0, 1'b1, 48'hC0FF_EE00_1234, 1'b0, '0, '0, NODES, 1'b1));
        add_row(OP_HEARTBEAT, ones, 8'h3C, 8'hC3, 48'd2001, 1'b0, none);
        add_row(OP_READ, '0, '0, '0, 48'd92000, 1'b0, none);
    endtask

    initial begin : main
        t_beat none;
        logic [TIME_W-1:0] cur_time;
        logic [MAC_W-1:0] mac_r;
        logic [TMO_W-1:0] tmo_set[5];
        logic op_r;
        int r;
        int span;
        none = '0;
        err_count = 0;
        n_hb = 0;
        n_read = 0;
        n_full = 0;
        n_beats = 0;
        node_cnt = 0;
        node_tmo = TMO_RESET;
        for (int i = 0; i < NODES; i++) tbl_onl[i] = 1'b0;
        idle_ok = 1'b1;
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_operation     <= OP_HEARTBEAT;
        i_mac           <= '0;
        i_summary_state <= '0;
        i_machine_state <= '0;
        i_now_ms        <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_directed();
        foreach (dir_rows[k]) begin
            send_item(dir_rows[k].op, dir_rows[k].mac, dir_rows[k].ss, dir_rows[k].ms,
                      dir_rows[k].now, dir_rows[k].typed, dir_rows[k].fixed);
        end
        drain();

        tmo_set[0] = '0;
        tmo_set[1] = '1;
        tmo_set[2] = TMO_W'($urandom_range(1, 24'hFFFFFE));
        tmo_set[3] = TMO_RESET;
        tmo_set[4] = TMO_W'($urandom_range(1, 2000));
        cur_time = 48'd100000;
        for (int p = 0; p < 5; p++) begin
            write_timeout(tmo_set[p]);
            idle_ok = (p != 2);
            span = int'(tmo_set[p] / 8) + 2;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ($urandom_range(0, 99) < 4) begin
                    cur_time = {16'($urandom), 32'($urandom)};
                end else begin
                    cur_time = cur_time + TIME_W'($urandom_range(0, span));
                end
                r = $urandom_range(0, 99);
                mac_r = {16'($urandom), 32'($urandom)};
                op_r = (r < 20) ? OP_READ : OP_HEARTBEAT;
                if (r >= 30 && node_cnt > 0) begin
                    mac_r = tbl_mac[$urandom_range(0, node_cnt - 1)];
                end
                send_item(op_r, mac_r, BYTE_W'($urandom), BYTE_W'($urandom), cur_time,
                          1'b0, none);
            end
            drain();
        end

        $display("Covered %0d heartbeats (%0d refused on a full table) and %0d reads,",
                 n_hb, n_full, n_read);
        $display("%0d beats checked over offline timeouts of 0, max, reset and random.",
                 n_beats);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Timeout with %0d beats outstanding", expected_beats.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
